### design/lsr_pkg.sv
// Shared types and constants for the LIN slave responder.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package lsr_pkg;

    localparam int LSR_ID_COUNT     = 64;
    localparam int LSR_MAX_RESPONSE = 8;

    localparam logic [7:0] CHECK_BYTE_RESET = 8'h42;

    // event codes carried in the input word
    localparam logic [2:0] OP_BREAK = 3'd0;
    localparam logic [2:0] OP_BYTE  = 3'd1;
    localparam logic [2:0] OP_TXRDY = 3'd2;
    localparam logic [2:0] OP_LINERR = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    // frame sequence phases, reported on the output word
    localparam logic [2:0] PH_BREAK = 3'd0;
    localparam logic [2:0] PH_ID    = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_CHECK = 3'd3;
    localparam logic [2:0] PH_FIN   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic cap;   // latch the accepted input word
        logic rd;    // issue table reads
        logic exec;  // apply the event, load the output word
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } ctrl_sts_t;

endpackage

### design/lin_slave_responder_unit.sv
// LIN slave responder: top level joining controller and datapath.
// Input stream carries bus events and table loads, output stream carries
// one result word per event, cfg_we/cfg_wdata write the check byte.
// Each input word yields exactly one output word. Input word fields, s_tuser
// holds the event code and s_tdata the operands; output flags sit in m_tuser.
// Timing: an accepted word is latched, the length and response tables are
// read in the next cycle (registered memory read), and the event is then
// applied in the execute state, which loads the output register; execution
// waits there while the previous output word is still held. A new word is
// accepted only after the last one has been applied (latch, read, execute).
// If the receiver stalls, the finished word waits in the output register;
// the next word is still accepted and read, and is applied once the held
// word has been taken.
// Reset: sequence returns to await break, capture bytes and length table
// clear at once (per-id valid flags), response bytes stay undefined until
// loaded, the check byte returns to 0x42. No clearing pass is needed.
// Depends on lsr_pkg, lsr_ctrl, lsr_datapath.
`timescale 1ns / 1ps

module lin_slave_responder_unit #(
    parameter int ID_COUNT     = lsr_pkg::LSR_ID_COUNT,
    parameter int MAX_RESPONSE = lsr_pkg::LSR_MAX_RESPONSE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_byte[7:0], table_id[13:8], table_len[17:14], table_pos[20:18],
    // table_byte[28:21], zero[31:29]
    input  logic [31:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte[7:0], frame_id[13:8], frame_data[77:14], frame_check[85:78],
    // phase[88:86], zero[95:89]
    output logic [95:0] m_tdata,
    // tx_valid[0], frame_valid[1]
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import lsr_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    lsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsr_datapath #(
        .ID_COUNT     (ID_COUNT),
        .MAX_RESPONSE (MAX_RESPONSE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### design/lsr_ctrl.sv
// Sequencing controller for the LIN slave responder.
// Depends on lsr_pkg for the command and status structs.
`timescale 1ns / 1ps

module lsr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lsr_pkg::ctrl_sts_t sts,
    output lsr_pkg::ctrl_cmd_t cmd
);
    import lsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold here while the previous result is still unread
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_READ && cmd.rd))
        else $error("accepted word not followed by table read");

    a_read_execs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> (state_reg == ST_EXEC))
        else $error("table read not followed by execute state");

    a_exec_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.rd) |-> !s_tready)
        else $error("input ready while a word is in flight");

endmodule

### design/lsr_datapath.sv
// Datapath of the LIN slave responder: input latch, length and response
// tables, frame sequence state, capture registers and output word.
// Depends on lsr_pkg; driven by lsr_ctrl commands.
`timescale 1ns / 1ps

module lsr_datapath #(
    parameter int ID_COUNT     = lsr_pkg::LSR_ID_COUNT,
    parameter int MAX_RESPONSE = lsr_pkg::LSR_MAX_RESPONSE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsr_pkg::ctrl_cmd_t cmd,
    output lsr_pkg::ctrl_sts_t sts,
    input  logic [31:0]        s_tdata,
    input  logic [2:0]         s_tuser,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [95:0]        m_tdata,
    output logic [1:0]         m_tuser
);
    import lsr_pkg::*;

    localparam int ID_AW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int POS_AW = (MAX_RESPONSE > 1) ? $clog2(MAX_RESPONSE) : 1;
    localparam int LEN_W  = $clog2(MAX_RESPONSE + 1);
    localparam int RSP_DEPTH = ID_COUNT * MAX_RESPONSE;
    localparam int RA_W   = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;

    // latched input word
    logic [2:0] op_reg;
    logic [7:0] rx_reg;
    logic [5:0] tid_reg;
    logic [3:0] tlen_reg;
    logic [2:0] tpos_reg;
    logic [7:0] tbyte_reg;

    logic [7:0] check_byte_reg;

    // frame sequence state
    logic [2:0] step_reg, step_next;
    logic [3:0] send_pos_reg, send_pos_next;
    logic [3:0] capture_pos_reg, capture_pos_next;
    logic [5:0] active_id_reg, active_id_next;
    logic [7:0] capture_check_reg, capture_check_next;
    logic [7:0] capture_reg [MAX_RESPONSE];

    // tables
    logic [LEN_W-1:0]    len_mem [ID_COUNT];
    logic [ID_COUNT-1:0] len_valid_reg;
    logic [7:0]          rsp_mem [RSP_DEPTH];

    logic [LEN_W-1:0] len_q_reg;
    logic             len_ok_reg;
    logic [7:0]       rsp_q_reg;
    logic             rsp_ok_reg;

    // output word
    logic        m_tvalid_reg;
    logic        tx_valid_reg, frame_valid_reg;
    logic [7:0]  tx_byte_reg, frame_check_reg;
    logic [5:0]  frame_id_reg;
    logic [63:0] frame_data_reg;
    logic [2:0]  phase_reg;

    // read-side addressing
    logic [5:0]      rd_id;
    logic            rd_id_ok;
    logic [RA_W-1:0] rd_addr;

    // write-side addressing
    logic            tbl_id_ok;
    logic [RA_W-1:0] wr_addr;
    logic [LEN_W-1:0] tlen_clamped;

    // execute results
    logic [LEN_W-1:0] len_cur;
    logic [7:0]       byte_cur;
    logic [3:0]       sp_inc;
    logic [2:0]       send_step;
    logic             tbl_we;
    logic             cap_we;
    logic             tx_v, fr_v;
    logic [7:0]       tx_b;
    logic [63:0]      cap_data;

    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg    <= s_tuser;
            rx_reg    <= s_tdata[7:0];
            tid_reg   <= s_tdata[13:8];
            tlen_reg  <= s_tdata[17:14];
            tpos_reg  <= s_tdata[20:18];
            tbyte_reg <= s_tdata[28:21];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_byte_reg <= CHECK_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            check_byte_reg <= cfg_wdata;
        end
    end

    // the id byte picks its own length; otherwise the active frame is read
    always_comb
    begin
        rd_id    = (op_reg == OP_BYTE && step_reg == PH_ID) ? rx_reg[5:0] : active_id_reg;
        rd_id_ok = int'(rd_id) < ID_COUNT;
        rd_addr  = RA_W'(RA_W'(rd_id) * RA_W'(MAX_RESPONSE) + RA_W'(send_pos_reg));
    end

    always_comb
    begin
        tbl_id_ok    = int'(tid_reg) < ID_COUNT;
        wr_addr      = RA_W'(RA_W'(tid_reg) * RA_W'(MAX_RESPONSE) + RA_W'(tpos_reg));
        tlen_clamped = (int'(tlen_reg) > MAX_RESPONSE) ? LEN_W'(MAX_RESPONSE)
                                                       : LEN_W'(tlen_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            len_q_reg <= len_mem[rd_id[ID_AW-1:0]];
            rsp_q_reg <= rsp_mem[rd_addr];
        end
        if (cmd.exec && tbl_we)
        begin
            len_mem[tid_reg[ID_AW-1:0]] <= tlen_clamped;
            if (int'(tpos_reg) < MAX_RESPONSE)
            begin
                rsp_mem[wr_addr] <= tbyte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg <= '0;
            len_ok_reg    <= 1'b0;
            rsp_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.rd)
            begin
                len_ok_reg <= rd_id_ok && len_valid_reg[rd_id[ID_AW-1:0]];
                rsp_ok_reg <= rd_id_ok && (int'(send_pos_reg) < MAX_RESPONSE);
            end
            if (cmd.exec && tbl_we)
            begin
                len_valid_reg[tid_reg[ID_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        cap_data = '0;
        for (int i = 0; i < MAX_RESPONSE; i++)
        begin
            cap_data[8*i +: 8] = capture_reg[i];
        end
    end

    always_comb
    begin
        len_cur   = len_ok_reg ? len_q_reg : '0;
        byte_cur  = rsp_ok_reg ? rsp_q_reg : 8'h00;
        sp_inc    = send_pos_reg + 4'd1;
        send_step = (sp_inc >= 4'(len_cur)) ? PH_CHECK : PH_DATA;

        step_next          = step_reg;
        send_pos_next      = send_pos_reg;
        capture_pos_next   = capture_pos_reg;
        active_id_next     = active_id_reg;
        capture_check_next = capture_check_reg;
        tbl_we = 1'b0;
        cap_we = 1'b0;
        tx_v   = 1'b0;
        tx_b   = 8'h00;
        fr_v   = 1'b0;

        case (op_reg)
            OP_BREAK:
            begin
                if (step_reg == PH_BREAK)
                begin
                    step_next = PH_ID;
                end
            end
            OP_BYTE:
            begin
                case (step_reg)
                    PH_ID:
                    begin
                        if (len_cur != '0)
                        begin
                            active_id_next = rx_reg[5:0];
                            tx_v           = 1'b1;
                            tx_b           = byte_cur;
                            send_pos_next  = sp_inc;
                            step_next      = send_step;
                        end
                        else
                        begin
                            step_next = PH_BREAK;
                        end
                    end
                    PH_DATA:
                    begin
                        // echoes beyond the capture depth are dropped
                        if (int'(capture_pos_reg) < MAX_RESPONSE)
                        begin
                            cap_we           = 1'b1;
                            capture_pos_next = capture_pos_reg + 4'd1;
                        end
                    end
                    PH_CHECK:
                    begin
                        capture_check_next = rx_reg;
                    end
                    default:
                    begin
                        step_next        = PH_BREAK;
                        send_pos_next    = '0;
                        capture_pos_next = '0;
                    end
                endcase
            end
            OP_TXRDY:
            begin
                case (step_reg)
                    PH_DATA:
                    begin
                        tx_v          = 1'b1;
                        tx_b          = byte_cur;
                        send_pos_next = sp_inc;
                        step_next     = send_step;
                    end
                    PH_CHECK:
                    begin
                        tx_v      = 1'b1;
                        tx_b      = check_byte_reg;
                        step_next = PH_FIN;
                    end
                    PH_FIN:
                    begin
                        fr_v             = 1'b1;
                        step_next        = PH_BREAK;
                        send_pos_next    = '0;
                        capture_pos_next = '0;
                    end
                    default:
                    begin
                        step_next        = PH_BREAK;
                        send_pos_next    = '0;
                        capture_pos_next = '0;
                    end
                endcase
            end
            OP_LINERR:
            begin
                step_next        = PH_BREAK;
                send_pos_next    = '0;
                capture_pos_next = '0;
            end
            OP_LOAD:
            begin
                tbl_we = tbl_id_ok;
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= PH_BREAK;
            send_pos_reg      <= '0;
            capture_pos_reg   <= '0;
            active_id_reg     <= '0;
            capture_check_reg <= '0;
            for (int i = 0; i < MAX_RESPONSE; i++)
            begin
                capture_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            step_reg          <= step_next;
            send_pos_reg      <= send_pos_next;
            capture_pos_reg   <= capture_pos_next;
            active_id_reg     <= active_id_next;
            capture_check_reg <= capture_check_next;
            if (cap_we)
            begin
                capture_reg[capture_pos_reg[POS_AW-1:0]] <= rx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            tx_valid_reg    <= tx_v;
            tx_byte_reg     <= tx_b;
            frame_valid_reg <= fr_v;
            frame_id_reg    <= fr_v ? active_id_reg : 6'd0;
            frame_data_reg  <= fr_v ? cap_data : 64'd0;
            frame_check_reg <= fr_v ? capture_check_reg : 8'h00;
            phase_reg       <= step_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {frame_valid_reg, tx_valid_reg};
    assign m_tdata  = {7'd0, phase_reg, frame_check_reg, frame_data_reg,
                       frame_id_reg, tx_byte_reg};

    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == PH_BREAK || step_reg == PH_ID) |-> (send_pos_reg == 4'd0))
        else $error("send position not cleared outside a frame");

    a_capture_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(capture_pos_reg) <= MAX_RESPONSE)
        else $error("capture position past capture depth");

    a_exec_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten before it was taken");

    a_exec_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (m_tvalid && phase_reg == $past(step_next)))
        else $error("executed event did not present its word");

endmodule
